// File: sv/rp2r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rp2r_pkg;

  localparam int DefMaxRows = 3;

  // internal widths
  localparam int CordW = 19;  // cos/sin and CORDIC x/y, Q.16
  localparam int ZW    = 20;  // CORDIC angle accumulator, Q.16
  localparam int DiffW = 33;  // position difference, Q16.16
  localparam int R2W   = 19;  // wrapped heading residual, Q.16
  localparam int PdW   = 37;  // rotated delta, Q.16
  localparam int ResW  = 38;  // position residual, Q.16
  localparam int CordSteps = 16;

  localparam int PiQ16     = 205887;
  localparam int HalfPiQ16 = 102944;
  localparam int TwoPiQ16  = 411775;
  localparam int GainQ16   = 39797;

  typedef enum logic [2:0] {
    CFG_ROW0  = 3'd0,
    CFG_ROW1  = 3'd1,
    CFG_ROW2  = 3'd2,
    CFG_ROWS  = 3'd3,
    CFG_MDX   = 3'd4,
    CFG_MDY   = 3'd5,
    CFG_MDTH  = 3'd6,
    CFG_SPARE = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [15:0] first_heading;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [15:0] second_heading;
  } in_t;

  typedef struct packed {
    logic        [1:0]  row_number;
    logic signed [39:0] residual;
    logic signed [39:0] jac_first_x;
    logic signed [39:0] jac_first_y;
    logic signed [39:0] jac_first_heading;
    logic signed [39:0] jac_second_x;
    logic signed [39:0] jac_second_y;
    logic signed [39:0] jac_second_heading;
    logic               last_row;
  } out_t;

  // cos/sin plus what the rotation needs
  typedef struct packed {
    logic signed [CordW-1:0] c;
    logic signed [CordW-1:0] s;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [R2W-1:0]   r2;
  } front_t;

  // per-item geometry held while rows go out
  typedef struct packed {
    logic signed [CordW-1:0] c;
    logic signed [CordW-1:0] s;
    logic signed [PdW-1:0]   pd0;
    logic signed [PdW-1:0]   pd1;
    logic signed [ResW-1:0]  r0;
    logic signed [ResW-1:0]  r1;
    logic signed [R2W-1:0]   r2;
  } geo_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 20'sd51472;
      1:  a = 20'sd30385;
      2:  a = 20'sd16055;
      3:  a = 20'sd8150;
      4:  a = 20'sd4091;
      5:  a = 20'sd2047;
      6:  a = 20'sd1024;
      7:  a = 20'sd512;
      8:  a = 20'sd256;
      9:  a = 20'sd128;
      10: a = 20'sd64;
      11: a = 20'sd32;
      12: a = 20'sd16;
      13: a = 20'sd8;
      14: a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [55:0] v);
    logic signed [39:0] r;
    if (v > 56'sd549755813887) begin
      r = 40'sh7F_FFFF_FFFF;
    end else if (v < -56'sd549755813888) begin
      r = 40'sh80_0000_0000;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/rp2r_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rp2r_front import rp2r_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  in_t                in_data,
  input  logic signed [15:0] meas_dtheta,
  output logic               out_valid,
  output front_t             out_front
);

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
    logic                    flip;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [R2W-1:0]   r2;
  } cord_t;

  cord_t                 st [0:CordSteps];
  logic [CordSteps:0]    v;
  cord_t                 prep;
  logic signed [ZW-1:0]  z_raw;
  logic signed [17:0]    dth;
  logic signed [21:0]    r2w;

  // quadrant fold and heading wrap
  always_comb begin
    z_raw = {in_data.first_heading[15], in_data.first_heading, 3'b000};
    prep.x = CordW'(GainQ16);
    prep.y = '0;
    prep.flip = 1'b0;
    prep.z = z_raw;
    if (z_raw > ZW'(HalfPiQ16)) begin
      prep.z = z_raw - ZW'(PiQ16);
      prep.flip = 1'b1;
    end else if (z_raw < -ZW'(HalfPiQ16)) begin
      prep.z = z_raw + ZW'(PiQ16);
      prep.flip = 1'b1;
    end
    prep.dx = DiffW'(in_data.second_x) - DiffW'(in_data.first_x);
    prep.dy = DiffW'(in_data.second_y) - DiffW'(in_data.first_y);
    dth = 18'(in_data.second_heading) - 18'(in_data.first_heading) - 18'(meas_dtheta);
    r2w = {dth[17], dth, 3'b000};
    if (r2w >= 22'sd617663) begin
      r2w = r2w - 22'sd823550;
    end else if (r2w >= 22'sd205888) begin
      r2w = r2w - 22'sd411775;
    end else if (r2w < -22'sd617662) begin
      r2w = r2w + 22'sd823550;
    end else if (r2w < -22'sd205887) begin
      r2w = r2w + 22'sd411775;
    end
    prep.r2 = r2w[R2W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v <= {v[CordSteps-1:0], in_valid};
      out_valid <= v[CordSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= prep;
      out_front.c <= st[CordSteps].flip ? -st[CordSteps].x : st[CordSteps].x;
      out_front.s <= st[CordSteps].flip ? -st[CordSteps].y : st[CordSteps].y;
      out_front.dx <= st[CordSteps].dx;
      out_front.dy <= st[CordSteps].dy;
      out_front.r2 <= st[CordSteps].r2;
    end
  end

  for (genvar i = 0; i < CordSteps; i++) begin : g_step
    cord_t nx;
    always_comb begin
      nx = st[i];
      if (!st[i].z[ZW-1]) begin
        nx.x = st[i].x - (st[i].y >>> i);
        nx.y = st[i].y + (st[i].x >>> i);
        nx.z = st[i].z - atan_q16(i);
      end else begin
        nx.x = st[i].x + (st[i].y >>> i);
        nx.y = st[i].y - (st[i].x >>> i);
        nx.z = st[i].z + atan_q16(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nx;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/rp2r_rotate.sv
`timescale 1ns / 1ps
`default_nettype none

module rp2r_rotate import rp2r_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  front_t             in_front,
  input  logic signed [31:0] meas_dx,
  input  logic signed [31:0] meas_dy,
  output logic               out_valid,
  output geo_t               out_geo
);

  logic                    v1;
  logic signed [51:0]      p_cdx, p_sdy, p_cdy, p_sdx;
  logic signed [CordW-1:0] c1, s1;
  logic signed [R2W-1:0]   r21;
  logic signed [52:0]      sum0, sum1;
  logic signed [PdW-1:0]   pd0, pd1;

  always_comb begin
    sum0 = 53'(p_cdx) + 53'(p_sdy) + 53'sd32768;
    sum1 = 53'(p_cdy) - 53'(p_sdx) + 53'sd32768;
    pd0 = PdW'(sum0 >>> 16);
    pd1 = PdW'(sum1 >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cdx <= in_front.c * in_front.dx;
      p_sdy <= in_front.s * in_front.dy;
      p_cdy <= in_front.c * in_front.dy;
      p_sdx <= in_front.s * in_front.dx;
      c1 <= in_front.c;
      s1 <= in_front.s;
      r21 <= in_front.r2;
      out_geo.c <= c1;
      out_geo.s <= s1;
      out_geo.pd0 <= pd0;
      out_geo.pd1 <= pd1;
      out_geo.r0 <= ResW'(pd0) - ResW'(meas_dx);
      out_geo.r1 <= ResW'(pd1) - ResW'(meas_dy);
      out_geo.r2 <= r21;
    end
  end

endmodule

`default_nettype wire

// File: sv/rp2r_rows.sv
`timescale 1ns / 1ps
`default_nettype none

module rp2r_rows import rp2r_pkg::*; #(
  parameter int MAX_ROWS = DefMaxRows
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        hold_valid,
  input  geo_t        geo,
  input  logic [47:0] info_row_zero,
  input  logic [47:0] info_row_one,
  input  logic [47:0] info_row_two,
  input  logic [1:0]  rows_in_use,
  output logic        release_hold,
  output logic        out_valid,
  output out_t        out_data
);

  logic [1:0]         row;
  logic [1:0]         nrows;
  logic [1:0]         nlast;
  logic               last;
  logic [47:0]        coef;
  logic signed [15:0] a0, a1, a2;

  logic               pv;
  logic [1:0]         prow;
  logic               plast;
  logic signed [53:0] m0, m1;
  logic signed [34:0] m2;
  logic signed [52:0] j0, j1;
  logic signed [34:0] a0c, a1s, a0s, a1c;
  logic signed [15:0] pa2;
  logic signed [39:0] jsx, jsy;

  always_comb begin
    nrows = (rows_in_use == 2'd0) ? 2'd1 : rows_in_use;
    if (int'(nrows) > MAX_ROWS) begin
      nrows = 2'(MAX_ROWS);
    end
    nlast = nrows - 2'd1;
    last = (row == nlast);
    release_hold = hold_valid && last;
    case (row)
      2'd0: coef = info_row_zero;
      2'd1: coef = info_row_one;
      default: coef = info_row_two;
    endcase
    a0 = coef[15:0];
    a1 = coef[31:16];
    a2 = coef[47:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      pv <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      if (hold_valid) begin
        row <= last ? 2'd0 : row + 2'd1;
      end
      pv <= hold_valid;
      out_valid <= pv;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      prow <= row;
      plast <= last;
      m0 <= a0 * geo.r0;
      m1 <= a1 * geo.r1;
      m2 <= a2 * geo.r2;
      j0 <= a0 * geo.pd1;
      j1 <= a1 * geo.pd0;
      a0c <= a0 * geo.c;
      a1s <= a1 * geo.s;
      a0s <= a0 * geo.s;
      a1c <= a1 * geo.c;
      pa2 <= a2;
    end
  end

  // round, saturate
  always_comb begin
    jsx = sat40((56'(a0c) - 56'(a1s) + 56'sd128) >>> 8);
    jsy = sat40((56'(a0s) + 56'(a1c) + 56'sd128) >>> 8);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.row_number <= prow;
      out_data.last_row <= plast;
      out_data.residual <= sat40((56'(m0) + 56'(m1) + 56'(m2) + 56'sd128) >>> 8);
      out_data.jac_second_x <= jsx;
      out_data.jac_second_y <= jsy;
      out_data.jac_first_x <= sat40(-56'(jsx));
      out_data.jac_first_y <= sat40(-56'(jsy));
      out_data.jac_first_heading <=
        sat40((56'(j0) - 56'(j1) - (56'(pa2) <<< 16) + 56'sd128) >>> 8);
      out_data.jac_second_heading <= 40'(pa2) <<< 8;
    end
  end

endmodule

`default_nettype wire

// File: sv/relative_pose_2d_residual_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Carries
// in      | request   | in_valid/in_stall  | in_t: two poses
// out     | result    | out_valid/out_stall| out_t: one row per result
// cfg     | write     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Pipeline from the accepting edge to the first valid row: prep,
// 16 CORDIC steps, CORDIC sign fix, two rotate stages, row products, row sums.
// A request gives 1 to 3 rows, one per cycle while the output is not frozen; the
// row sequencer holds one request until its last row is sent.
// Reset: rst synchronous, clears valid bits; rows_in_use resets to 3.
// out_stall with out_valid set freezes the whole pipeline; in_stall rises when it is frozen or
// the row sequencer still has rows of the current request to send.

module relative_pose_2d_residual_unit import rp2r_pkg::*; #(
  parameter int MAX_ROWS = DefMaxRows
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [47:0]        info_row_zero, info_row_one, info_row_two;
  logic [1:0]         rows_in_use;
  logic signed [31:0] meas_dx, meas_dy;
  logic signed [15:0] meas_dtheta;

  logic   en;        // back end moves
  logic   front_en;  // everything up to the hold register moves
  logic   front_valid;
  front_t front;
  logic   hold_valid;
  geo_t   geo;
  logic   release_hold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      info_row_zero <= '0;
      info_row_one <= '0;
      info_row_two <= '0;
      rows_in_use <= 2'd3;
      meas_dx <= '0;
      meas_dy <= '0;
      meas_dtheta <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW0: info_row_zero <= cfg_data;
        CFG_ROW1: info_row_one <= cfg_data;
        CFG_ROW2: info_row_two <= cfg_data;
        CFG_ROWS: rows_in_use <= cfg_data[1:0];
        CFG_MDX:  meas_dx <= cfg_data[31:0];
        CFG_MDY:  meas_dy <= cfg_data[31:0];
        CFG_MDTH: meas_dtheta <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // output register is free or being emptied
  assign en = !out_valid || !out_stall;
  // hold register is free or sends its last row this cycle
  assign front_en = en && (!hold_valid || release_hold);
  assign in_stall = !front_en;

  rp2r_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (front_en),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .meas_dtheta (meas_dtheta),
    .out_valid   (front_valid),
    .out_front   (front)
  );

  rp2r_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (front_en),
    .in_valid  (front_valid),
    .in_front  (front),
    .meas_dx   (meas_dx),
    .meas_dy   (meas_dy),
    .out_valid (hold_valid),
    .out_geo   (geo)
  );

  rp2r_rows #(
    .MAX_ROWS (MAX_ROWS)
  ) u_rows (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .hold_valid    (hold_valid),
    .geo           (geo),
    .info_row_zero (info_row_zero),
    .info_row_one  (info_row_one),
    .info_row_two  (info_row_two),
    .rows_in_use   (rows_in_use),
    .release_hold  (release_hold),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

  // frozen output stalls the input side
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output frozen");

  // a held request with rows left blocks new requests
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !release_hold |-> in_stall)
    else $error("input taken while rows pending");

  // a non-final row is never the highest row
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_row |-> out_data.row_number != 2'd2)
    else $error("row number past last row");

endmodule

`default_nettype wire
